// ----- rtl/core/oaat_pkg.sv -----
package oaat_pkg;

  localparam int unsigned HASH_W   = 32;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned SIZE_W   = 17;
  localparam int unsigned BUCKET_W = 16;

  localparam int unsigned MIX_SHL = 10;
  localparam int unsigned MIX_SHR = 6;
  localparam int unsigned FIN_SHL_A = 3;
  localparam int unsigned FIN_SHR_B = 11;
  localparam int unsigned FIN_SHL_C = 15;

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(8192);
  localparam logic [SIZE_W-1:0] SIZE_MAX   = SIZE_W'(65536);

  localparam int unsigned PADDR_W = 3;
  localparam logic [0:0] REG_TABLE_SIZE = 1'b0;

  typedef struct packed {
    logic [BYTE_W-1:0] key_byte;
    logic              key_last;
  } in_req_t;

  typedef struct packed {
    logic [BUCKET_W-1:0] bucket_index;
    logic [HASH_W-1:0]   full_hash;
  } out_res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MIX_SHL,
    ST_MIX_XOR,
    ST_FIN_A,
    ST_FIN_B,
    ST_FIN_C,
    ST_DIV,
    ST_EMIT
  } state_e;

  typedef enum logic {
    ALU_ADD,
    ALU_XOR
  } alu_op_e;

endpackage

// ----- rtl/core/oaat_mod.sv -----
module oaat_mod (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [oaat_pkg::HASH_W-1:0]       dividend_i,
  input  logic [oaat_pkg::SIZE_W-1:0]       divisor_i,
  output logic                              done_o,
  output logic [oaat_pkg::BUCKET_W-1:0]     rem_o
);

  localparam int unsigned CNT_W = $clog2(oaat_pkg::HASH_W);

  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  logic [CNT_W-1:0]              cnt_q, cnt_d;
  logic [oaat_pkg::HASH_W-1:0]   quo_q, quo_d;
  logic [oaat_pkg::SIZE_W-1:0]   rem_q, rem_d;
  logic [oaat_pkg::SIZE_W-1:0]   div_q, div_d;
  logic [oaat_pkg::SIZE_W:0]     shifted;
  logic [oaat_pkg::SIZE_W:0]     diff;

  assign shifted = {rem_q, quo_q[oaat_pkg::HASH_W-1]};
  assign diff    = shifted - {1'b0, div_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    div_d  = div_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = dividend_i;
      rem_d  = '0;
      div_d  = divisor_i;
    end else if (busy_q) begin
      quo_d = {quo_q[oaat_pkg::HASH_W-2:0], 1'b0};
      if (shifted >= {1'b0, div_q}) begin
        rem_d = diff[oaat_pkg::SIZE_W-1:0];
      end else begin
        rem_d = shifted[oaat_pkg::SIZE_W-1:0];
      end
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(oaat_pkg::HASH_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q[oaat_pkg::BUCKET_W-1:0];

endmodule

// ----- rtl/core/one_at_a_time_hash_bucket.sv -----
// Steps: a mixed key byte passes the IDLE, MIX_SHL and MIX_XOR states, a skipped byte IDLE
// alone. A last byte adds FIN_A, FIN_B and FIN_C (avalanche), the bit-serial bucket divider
// and its done flag, and the output register load, which stalls while the previous result waits.
// Throughput: one key byte at a time; a new byte is taken while a result waits.
// Reset: asynchronous, active low; clears the running hash and counters and sets the table
// size to 8192. No clearing pass is needed.
module one_at_a_time_hash_bucket #(
  parameter int unsigned MAX_KEY_LENGTH = 256
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  oaat_pkg::in_req_t               in_req_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output oaat_pkg::out_res_t              out_req_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [oaat_pkg::PADDR_W-1:0]    paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  localparam int unsigned TAKEN_W = $clog2(MAX_KEY_LENGTH + 1);

  oaat_pkg::state_e                 state_q, state_d;
  logic [oaat_pkg::HASH_W-1:0]      hash_q, hash_d;
  logic [TAKEN_W-1:0]               taken_q, taken_d;
  logic                             stop_q, stop_d;
  logic                             last_q, last_d;
  logic [oaat_pkg::SIZE_W-1:0]      size_q;
  logic [oaat_pkg::SIZE_W-1:0]      eff_size;
  logic                             out_valid_q;
  oaat_pkg::out_res_t               out_res_q;

  logic                             in_accept;
  logic                             key_active;
  logic                             do_mix;
  logic                             in_ready;
  logic                             hash_we;
  logic                             div_start;
  logic                             out_load;
  logic                             clear_key;
  logic                             div_done;
  logic [oaat_pkg::BUCKET_W-1:0]    div_rem;

  oaat_pkg::alu_op_e                alu_op;
  logic [oaat_pkg::HASH_W-1:0]      alu_b;
  logic [oaat_pkg::HASH_W-1:0]      alu_y;

  logic                             cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite
                  && (paddr[2] == oaat_pkg::REG_TABLE_SIZE);
  assign prdata = (paddr[2] == oaat_pkg::REG_TABLE_SIZE)
                  ? {{(32 - oaat_pkg::SIZE_W){1'b0}}, size_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= oaat_pkg::SIZE_RESET;
    end else if (cfg_we) begin
      size_q <= pwdata[oaat_pkg::SIZE_W-1:0];
    end
  end

  always_comb begin
    if (size_q == '0) begin
      eff_size = oaat_pkg::SIZE_W'(1);
    end else if (size_q > oaat_pkg::SIZE_MAX) begin
      eff_size = oaat_pkg::SIZE_MAX;
    end else begin
      eff_size = size_q;
    end
  end

  assign in_accept  = in_valid_i && in_ready;
  assign key_active = !stop_q && (taken_q < TAKEN_W'(MAX_KEY_LENGTH));
  assign do_mix     = key_active && (in_req_i.key_byte != '0);

  always_comb begin
    alu_op = oaat_pkg::ALU_ADD;
    alu_b  = '0;
    unique case (state_q)
      oaat_pkg::ST_IDLE: begin
        alu_b = {{(oaat_pkg::HASH_W - oaat_pkg::BYTE_W){1'b0}}, in_req_i.key_byte};
      end
      oaat_pkg::ST_MIX_SHL: begin
        alu_b = hash_q << oaat_pkg::MIX_SHL;
      end
      oaat_pkg::ST_MIX_XOR: begin
        alu_op = oaat_pkg::ALU_XOR;
        alu_b  = hash_q >> oaat_pkg::MIX_SHR;
      end
      oaat_pkg::ST_FIN_A: begin
        alu_b = hash_q << oaat_pkg::FIN_SHL_A;
      end
      oaat_pkg::ST_FIN_B: begin
        alu_op = oaat_pkg::ALU_XOR;
        alu_b  = hash_q >> oaat_pkg::FIN_SHR_B;
      end
      oaat_pkg::ST_FIN_C: begin
        alu_b = hash_q << oaat_pkg::FIN_SHL_C;
      end
      default: begin
        alu_b = '0;
      end
    endcase
    alu_y = (alu_op == oaat_pkg::ALU_ADD) ? (hash_q + alu_b) : (hash_q ^ alu_b);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      oaat_pkg::ST_IDLE: begin
        if (in_accept) begin
          if (do_mix) begin
            state_d = oaat_pkg::ST_MIX_SHL;
          end else if (in_req_i.key_last) begin
            state_d = oaat_pkg::ST_FIN_A;
          end
        end
      end
      oaat_pkg::ST_MIX_SHL: state_d = oaat_pkg::ST_MIX_XOR;
      oaat_pkg::ST_MIX_XOR: begin
        state_d = last_q ? oaat_pkg::ST_FIN_A : oaat_pkg::ST_IDLE;
      end
      oaat_pkg::ST_FIN_A: state_d = oaat_pkg::ST_FIN_B;
      oaat_pkg::ST_FIN_B: state_d = oaat_pkg::ST_FIN_C;
      oaat_pkg::ST_FIN_C: state_d = oaat_pkg::ST_DIV;
      oaat_pkg::ST_DIV: begin
        if (div_done) begin
          state_d = oaat_pkg::ST_EMIT;
        end
      end
      oaat_pkg::ST_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = oaat_pkg::ST_IDLE;
        end
      end
      default: state_d = oaat_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    hash_we   = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    clear_key = 1'b0;
    unique case (state_q)
      oaat_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        hash_we  = in_accept && do_mix;
      end
      oaat_pkg::ST_MIX_SHL, oaat_pkg::ST_MIX_XOR,
      oaat_pkg::ST_FIN_A, oaat_pkg::ST_FIN_B: begin
        hash_we = 1'b1;
      end
      oaat_pkg::ST_FIN_C: begin
        hash_we   = 1'b1;
        div_start = 1'b1;
      end
      oaat_pkg::ST_DIV: begin
        hash_we = 1'b0;
      end
      oaat_pkg::ST_EMIT: begin
        out_load  = !out_valid_q || out_ready_i;
        clear_key = out_load;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_comb begin
    hash_d  = hash_q;
    taken_d = taken_q;
    stop_d  = stop_q;
    last_d  = last_q;
    if (hash_we) begin
      hash_d = alu_y;
    end
    if (in_accept) begin
      last_d = in_req_i.key_last;
      if (do_mix) begin
        taken_d = taken_q + TAKEN_W'(1);
      end else if (key_active) begin
        stop_d = 1'b1;
      end
    end
    if (clear_key) begin
      hash_d  = '0;
      taken_d = '0;
      stop_d  = 1'b0;
      last_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= oaat_pkg::ST_IDLE;
      hash_q      <= '0;
      taken_q     <= '0;
      stop_q      <= 1'b0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      hash_q  <= hash_d;
      taken_q <= taken_d;
      stop_q  <= stop_d;
      last_q  <= last_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_res_q.bucket_index <= div_rem;
      out_res_q.full_hash    <= hash_q;
    end
  end

  oaat_mod u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (alu_y),
    .divisor_i  (eff_size),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  assign in_ready_o  = in_ready;
  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_res_q;

  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == oaat_pkg::ST_DIV))
    else $error("divider finished outside the divide state");

  a_bucket_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> ({1'b0, out_res_q.bucket_index} < eff_size))
    else $error("bucket index not below the table size");

  a_taken_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    taken_q <= TAKEN_W'(MAX_KEY_LENGTH))
    else $error("byte count passed the key length cap");

  a_last_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && in_req_i.key_last) |=> !in_ready_o)
    else $error("new request taken before the key was finalized");

endmodule
